FILE: design/vn_pkg.sv
package vn_pkg;

    localparam int COMP_W  = 16;
    localparam int SQ_W    = 34;
    localparam int ROOT_W  = 17;
    localparam int NUM_W   = 30;
    localparam int QUOT_W  = 15;
    localparam logic signed [COMP_W-1:0] ONE_Q14 = 16'sd16384;

    typedef struct packed {
        logic        neg;
        logic [NUM_W-1:0] num;
        logic [QUOT_W:0]  quot;
    } div_lane_t;

endpackage

FILE: design/vn_pipe.sv
module vn_pipe (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic in_valid,
    input  logic signed [15:0] in_x,
    input  logic signed [15:0] in_y,
    input  logic signed [15:0] in_z,
    output logic out_valid,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y,
    output logic signed [15:0] out_z,
    output logic out_zero
);
    import vn_pkg::*;

    // stage counts: 1 square, 1 sum, 17 root, 1 divide set-up, 16 divide
    localparam int RS = ROOT_W;
    localparam int DS = QUOT_W + 1;
    localparam int NS = 3 + RS + DS;

    logic [NS-1:0] v_reg;

    // stage 1: squares
    logic signed [15:0] c1_reg [3];
    logic [31:0] sq_reg [3];

    // root stages: remainder, root, components and zero flag per stage; stage 0 holds the sum
    logic [SQ_W-1:0]  rem_reg  [RS+1];
    logic [SQ_W-1:0]  root_reg [RS+1];
    logic signed [15:0] cr_reg [RS+1][3];
    logic zr_reg [RS+1];

    // divide stages; stage 0 holds the set-up lanes
    div_lane_t dl_reg [DS+1][3];
    logic [ROOT_W-1:0] dr_reg [DS+1];
    logic zd_reg [DS+1];

    // advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    // square each component, then sum into the first root stage
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                c1_reg[i] <= (i == 0) ? in_x : (i == 1) ? in_y : in_z;
            end
            sq_reg[0] <= 32'(in_x * in_x);
            sq_reg[1] <= 32'(in_y * in_y);
            sq_reg[2] <= 32'(in_z * in_z);
            rem_reg[0]  <= SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
            root_reg[0] <= '0;
            cr_reg[0]   <= c1_reg;
            zr_reg[0]   <= (c1_reg[0] == 16'sd0) && (c1_reg[1] == 16'sd0)
                           && (c1_reg[2] == 16'sd0);
        end
    end

    // one root digit per stage, bit = 4^(RS-1-k)
    for (genvar k = 0; k < RS; k++) begin : g_root
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (RS - 1 - k));
        logic [SQ_W-1:0] trial;
        assign trial = root_reg[k] + BIT;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_reg[k] >= trial) begin
                    rem_reg[k+1]  <= rem_reg[k] - trial;
                    root_reg[k+1] <= (root_reg[k] >> 1) + BIT;
                end else begin
                    rem_reg[k+1]  <= rem_reg[k];
                    root_reg[k+1] <= root_reg[k] >> 1;
                end
                cr_reg[k+1] <= cr_reg[k];
                zr_reg[k+1] <= zr_reg[k];
            end
        end
    end

    // set up divide lanes: magnitude << 14 over root
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dl_reg[0][i].neg  <= cr_reg[RS][i][15];
                dl_reg[0][i].num  <= NUM_W'(17'(cr_reg[RS][i][15] ? -32'(cr_reg[RS][i])
                                                  : 32'(cr_reg[RS][i]))) << 14;
                dl_reg[0][i].quot <= '0;
            end
            dr_reg[0] <= ROOT_W'(root_reg[RS]);
            zd_reg[0] <= zr_reg[RS];
        end
    end

    // one quotient bit per stage, restoring
    for (genvar k = 0; k < DS; k++) begin : g_div
        localparam int SH = DS - 1 - k;
        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    if ((dl_reg[k][i].num >> SH) >= NUM_W'(dr_reg[k])) begin
                        dl_reg[k+1][i].num <= dl_reg[k][i].num
                                            - (NUM_W'(dr_reg[k]) << SH);
                        dl_reg[k+1][i].quot <= dl_reg[k][i].quot
                                             | ((QUOT_W+1)'(1) << SH);
                    end else begin
                        dl_reg[k+1][i].num  <= dl_reg[k][i].num;
                        dl_reg[k+1][i].quot <= dl_reg[k][i].quot;
                    end
                    dl_reg[k+1][i].neg <= dl_reg[k][i].neg;
                end
                dr_reg[k+1] <= dr_reg[k];
                zd_reg[k+1] <= zd_reg[k];
            end
        end
    end

    // apply sign, substitute fallback for zero vector
    function automatic logic signed [15:0] signed_q(input div_lane_t l);
        logic signed [15:0] q;
        q = signed'(16'(l.quot));
        return l.neg ? -q : q;
    endfunction

    assign out_valid = v_reg[NS-1];
    assign out_zero  = zd_reg[DS];
    assign out_x = zd_reg[DS] ? ONE_Q14 : signed_q(dl_reg[DS][0]);
    assign out_y = zd_reg[DS] ? 16'sd0 : signed_q(dl_reg[DS][1]);
    assign out_z = zd_reg[DS] ? 16'sd0 : signed_q(dl_reg[DS][2]);

    unused_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(v_reg)) else $error("valid bits moved while held");
    zero_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_zero |-> out_x == ONE_Q14) else $error("bad fallback");
    range_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> out_x <= ONE_Q14 && out_x >= -ONE_Q14)
        else $error("x out of range");

endmodule

FILE: design/vector3_normalise_core.sv
// Normalises one signed Q8.8 vector per beat to signed Q1.14 unit length.
// Input channel s_valid/s_ready with s_in_x, s_in_y, s_in_z; result channel
// m_valid/m_ready with m_out_x, m_out_y, m_out_z and m_was_zero.
// A zero vector gives x = 1.0, y = z = 0 and was_zero set.
// Pipeline: an accepted beat passes 1 square, 1 sum, 17 root digit, 1 divider
// set-up and 15 further quotient bit stages, and the 16th quotient stage
// feeds the output register, which drives m_valid.
// Throughput: one vector per cycle while m_ready does not stall the pipeline;
// the digit-per-stage root and divider lanes set the pipeline depth.
// The whole pipeline advances together; when m_ready is low with a result
// waiting, the pipeline holds and s_ready drops, so no beat is lost.
// Reset (aresetn, synchronous, active low) clears all valid bits.
module vector3_normalise_core (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic signed [15:0] s_in_x,
    input  logic signed [15:0] s_in_y,
    input  logic signed [15:0] s_in_z,
    output logic m_valid,
    input  logic m_ready,
    output logic signed [15:0] m_out_x,
    output logic signed [15:0] m_out_y,
    output logic signed [15:0] m_out_z,
    output logic m_was_zero
);
    logic en, pv, pz;
    logic signed [15:0] px, py, pzc;

    // advance when the output register is free or being drained
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    vn_pipe u_pipe (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_valid),
        .in_x(s_in_x), .in_y(s_in_y), .in_z(s_in_z),
        .out_valid(pv), .out_x(px), .out_y(py), .out_z(pzc), .out_zero(pz)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (en) begin
            m_valid <= pv;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_out_x    <= px;
            m_out_y    <= py;
            m_out_z    <= pzc;
            m_was_zero <= pz;
        end
    end

    hold_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x))
        else $error("result dropped under stall");
    zero_y: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_was_zero |-> m_out_y == 16'sd0 && m_out_z == 16'sd0)
        else $error("bad zero result");
    rdy_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready) else $error("stalled while empty");

endmodule
